// ===== rtl/rth_pkg.sv =====
`default_nettype none

package rth_pkg;

    localparam int COMP_W     = 8;
    localparam int HUE_W      = 9;
    localparam int PCT_W      = 7;
    localparam int HNUM_W     = 14;   // 60 * span, span <= 255
    localparam int SNUM_W     = 15;   // 100 * diff, diff <= 255
    localparam int HQ_W       = 6;    // hue quotient 0..60
    localparam int SQ_W       = 7;    // saturation quotient 0..100
    localparam int HSUM_W     = 10;   // offset plus quotient, up to 420
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = 2;    // restoring steps per divider stage

    localparam logic [HSUM_W-1:0] DEG_FULL  = HSUM_W'(360);
    localparam logic [HSUM_W-1:0] OFF_RED   = HSUM_W'(360);
    localparam logic [HSUM_W-1:0] OFF_GREEN = HSUM_W'(120);
    localparam logic [HSUM_W-1:0] OFF_BLUE  = HSUM_W'(240);
    localparam logic [PCT_W-1:0]  PCT_MAX   = PCT_W'(100);

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

    // after max/min search
    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic                grey;
        logic                black;
        logic [COMP_W-1:0]   mx;
        logic [COMP_W-1:0]   d;
        logic [COMP_W-1:0]   span;
    } minmax_t;

    // state carried through the divider stages
    typedef struct packed {
        sector_t             sector;
        logic                neg;
        logic                grey;
        logic                black;
        logic [COMP_W-1:0]   mx;
        logic [COMP_W-1:0]   d;
        logic [PCT_W-1:0]    val;
        logic [HNUM_W-1:0]   hue_rem;
        logic [HQ_W-1:0]     hue_quo;
        logic [SNUM_W-1:0]   sat_rem;
        logic [SQ_W-1:0]     sat_quo;
    } div_t;

    // Two restoring steps of both dividers for one pipeline stage.
    // Hue divides by d, saturation by mx; quotient bits go MSB first.
    function automatic div_t div_stage(input div_t x, input int stage);
        div_t                y;
        int                  j;
        int                  kh;
        int                  ks;
        logic [HNUM_W-1:0]   hsh;
        logic [SNUM_W-1:0]   ssh;
        y = x;
        for (j = 0; j < DIV_STEPS; j++) begin
            kh = HQ_W - 1 - DIV_STEPS * stage - j;
            ks = SQ_W - 1 - DIV_STEPS * stage - j;
            if (kh >= 0) begin
                hsh = HNUM_W'(y.d) << kh;
                if (y.hue_rem >= hsh) begin
                    y.hue_rem = y.hue_rem - hsh;
                    y.hue_quo = y.hue_quo | (HQ_W'(1) << kh);
                end
            end
            if (ks >= 0) begin
                ssh = SNUM_W'(y.mx) << ks;
                if (y.sat_rem >= ssh) begin
                    y.sat_rem = y.sat_rem - ssh;
                    y.sat_quo = y.sat_quo | (SQ_W'(1) << ks);
                end
            end
        end
        return y;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rth_channels.sv =====
`default_nettype none

interface rth_rgb_if import rth_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red_in;
    logic [COMP_W-1:0] green_in;
    logic [COMP_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface rth_hsv_if import rth_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue_deg;
    logic [PCT_W-1:0] sat_pct;
    logic [PCT_W-1:0] val_pct;

    modport source (output valid, output hue_deg, output sat_pct, output val_pct,
                    input ready);
    modport sink   (input valid, input hue_deg, input sat_pct, input val_pct,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/rth_front.sv =====
`default_nettype none

module rth_front
    import rth_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rth_rgb_if.sink   rgb,
    output logic      dn_valid,
    input  wire logic dn_ready,
    output div_t      dn_data
);

    minmax_t mm_reg;
    minmax_t mm_next;
    logic    mm_vld_reg;
    div_t    pr_reg;
    div_t    pr_next;
    logic    pr_vld_reg;
    logic    en_mm;
    logic    en_pr;

    logic [COMP_W-1:0]   mx;
    logic [COMP_W-1:0]   mn;
    logic [COMP_W-1:0]   p;
    logic [COMP_W-1:0]   q;
    logic [SNUM_W-1:0]   vnum;
    logic [SNUM_W:0]     vsum;

    assign en_pr     = !pr_vld_reg || dn_ready;
    assign en_mm     = !mm_vld_reg || en_pr;
    assign rgb.ready = en_mm;

    // max, min and sector; ties go red, then green
    always_comb
    begin
        mx = rgb.red_in;
        mn = rgb.red_in;
        if (rgb.green_in > mx) mx = rgb.green_in;
        if (rgb.blue_in  > mx) mx = rgb.blue_in;
        if (rgb.green_in < mn) mn = rgb.green_in;
        if (rgb.blue_in  < mn) mn = rgb.blue_in;
        if (mx == rgb.red_in)
        begin
            mm_next.sector = SECT_RED;
            p = rgb.green_in;
            q = rgb.blue_in;
        end
        else if (mx == rgb.green_in)
        begin
            mm_next.sector = SECT_GREEN;
            p = rgb.blue_in;
            q = rgb.red_in;
        end
        else
        begin
            mm_next.sector = SECT_BLUE;
            p = rgb.red_in;
            q = rgb.green_in;
        end
        mm_next.mx    = mx;
        mm_next.d     = mx - mn;
        mm_next.grey  = (mx == mn);
        mm_next.black = (mx == '0);
        mm_next.neg   = (q > p);
        mm_next.span  = (q > p) ? (q - p) : (p - q);
    end

    // constant products and value percent (divide by 255 via reciprocal)
    always_comb
    begin
        pr_next.sector  = mm_reg.sector;
        pr_next.neg     = mm_reg.neg;
        pr_next.grey    = mm_reg.grey;
        pr_next.black   = mm_reg.black;
        pr_next.mx      = mm_reg.mx;
        pr_next.d       = mm_reg.d;
        pr_next.hue_rem = (HNUM_W'(mm_reg.span) << 6) - (HNUM_W'(mm_reg.span) << 2);
        pr_next.sat_rem = (SNUM_W'(mm_reg.d) << 6) + (SNUM_W'(mm_reg.d) << 5)
                        + (SNUM_W'(mm_reg.d) << 2);
        pr_next.hue_quo = '0;
        pr_next.sat_quo = '0;
        vnum            = (SNUM_W'(mm_reg.mx) << 6) + (SNUM_W'(mm_reg.mx) << 5)
                        + (SNUM_W'(mm_reg.mx) << 2);
        vsum            = (SNUM_W + 1)'(vnum) + (SNUM_W + 1)'(vnum >> 8)
                        + (SNUM_W + 1)'(1);
        pr_next.val     = PCT_W'(vsum >> 8);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mm_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
        end
        else
        begin
            if (en_mm) mm_vld_reg <= rgb.valid;
            if (en_pr) pr_vld_reg <= mm_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_mm && rgb.valid) mm_reg <= mm_next;
        if (en_pr && mm_vld_reg) pr_reg <= pr_next;
    end

    assign dn_valid = pr_vld_reg;
    assign dn_data  = pr_reg;

endmodule

`default_nettype wire

// ===== rtl/rth_div.sv =====
`default_nettype none

module rth_div
    import rth_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  div_t      up_data,
    output logic      dn_valid,
    input  wire logic dn_ready,
    output div_t      dn_data
);

    div_t                  stg_reg [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] en;

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            div_t stg_next;
            logic vin;

            if (s == DIV_STAGES - 1)
            begin : g_last
                assign en[s] = !vld_reg[s] || dn_ready;
            end
            else
            begin : g_mid
                assign en[s] = !vld_reg[s] || en[s+1];
            end

            if (s == 0)
            begin : g_first
                assign stg_next = div_stage(up_data, s);
                assign vin      = up_valid;
            end
            else
            begin : g_chain
                assign stg_next = div_stage(stg_reg[s-1], s);
                assign vin      = vld_reg[s-1];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[s] <= 1'b0;
                else if (en[s])
                    vld_reg[s] <= vin;
            end

            always_ff @(posedge clk)
            begin
                if (en[s] && vin) stg_reg[s] <= stg_next;
            end
        end
    endgenerate

    assign up_ready = en[0];
    assign dn_valid = vld_reg[DIV_STAGES-1];
    assign dn_data  = stg_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/rth_back.sv =====
`default_nettype none

module rth_back
    import rth_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic up_valid,
    output logic      up_ready,
    input  div_t      up_data,
    rth_hsv_if.source hsv
);

    logic             out_vld_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [HUE_W-1:0] hue_next;
    logic [PCT_W-1:0] sat_reg;
    logic [PCT_W-1:0] sat_next;
    logic [PCT_W-1:0] val_reg;
    logic             en;

    logic [HSUM_W-1:0] base;
    logic [HSUM_W-1:0] hsum;
    logic              frac;

    assign en       = !out_vld_reg || hsv.ready;
    assign up_ready = en;

    // offset plus or minus the sector fraction; a negative fraction floors down
    always_comb
    begin
        case (up_data.sector)
            SECT_RED:   base = OFF_RED;
            SECT_GREEN: base = OFF_GREEN;
            SECT_BLUE:  base = OFF_BLUE;
            default:    base = OFF_BLUE;
        endcase
        frac = (up_data.hue_rem != '0);
        if (up_data.neg)
            hsum = base - HSUM_W'(up_data.hue_quo) - HSUM_W'(frac);
        else
            hsum = base + HSUM_W'(up_data.hue_quo);
        if (hsum >= DEG_FULL)
            hsum = hsum - DEG_FULL;
        hue_next = up_data.grey  ? '0 : HUE_W'(hsum);
        sat_next = up_data.black ? '0 : up_data.sat_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en && up_valid)
        begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= up_data.val;
        end
    end

    assign hsv.valid   = out_vld_reg;
    assign hsv.hue_deg = hue_reg;
    assign hsv.sat_pct = sat_reg;
    assign hsv.val_pct = val_reg;

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (hue_reg < HUE_W'(360)))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (sat_reg <= PCT_MAX))
        else $error("saturation out of range");

    a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (val_reg <= PCT_MAX))
        else $error("value out of range");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (en && up_valid) |=> out_vld_reg)
        else $error("item dropped at output register");

endmodule

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
`default_nettype none

// RGB to HSV converter for 8-bit pixels. Each item on the rgb channel carries
// one red, green and blue triple; the matching item on the hsv channel gives
// hue in whole degrees (0..359, 0 for grey) and saturation and value in whole
// percent (0..100), all truncated toward zero from the exact rationals. The
// block takes one item every clock while hsv is ready. An accepted item
// reaches hsv through seven register stages: two front stages (max/min
// search, then the constant products and the value percent), four stages of
// the two restoring dividers that form hue and saturation side by side, two
// quotient bits per stage, and the output register. Each stage holds its item
// while the stage below is full and stalled, so back-pressure on hsv fills
// bubbles first and then stalls the input.

module rgb_to_hsv_converter
    import rth_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rth_rgb_if.sink   rgb,
    rth_hsv_if.source hsv
);

    // front end to divider
    logic f_valid;
    logic f_ready;
    div_t f_data;

    // divider to output register
    logic d_valid;
    logic d_ready;
    div_t d_data;

    // min/max, sector, span, products, value percent
    rth_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rgb      (rgb),
        .dn_valid (f_valid),
        .dn_ready (f_ready),
        .dn_data  (f_data)
    );

    // hue fraction 60*span/diff and saturation 100*diff/max
    rth_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (f_valid),
        .up_ready (f_ready),
        .up_data  (f_data),
        .dn_valid (d_valid),
        .dn_ready (d_ready),
        .dn_data  (d_data)
    );

    // add sector offset, wrap, drop special cases, hold the result
    rth_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (d_valid),
        .up_ready (d_ready),
        .up_data  (d_data),
        .hsv      (hsv)
    );

endmodule

`default_nettype wire

// ===== test/hsv_result_checker.sv =====
`timescale 1ns / 100ps

module hsv_result_checker
    import rth_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    rth_rgb_if   rgb,
    rth_hsv_if   hsv,
    output int   mismatches,
    output int   pending,
    output int   checked,
    output int   greys,
    output int   blacks
);

    localparam int unsigned SEXTANT_DEG = 60;
    localparam int unsigned WRAP_DEG    = DEG_FULL;
    localparam int unsigned RED_BASE    = OFF_RED;
    localparam int unsigned GREEN_BASE  = OFF_GREEN;
    localparam int unsigned BLUE_BASE   = OFF_BLUE;
    localparam int unsigned PCT_SCALE   = PCT_MAX;
    localparam int unsigned FULL_SCALE  = (1 << COMP_W) - 1;
    localparam int          REPORT_MAX  = 10;

    // pixel that went in, with the hsv triple it must come out as
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [HUE_W-1:0]  hue;
        logic [PCT_W-1:0]  sat;
        logic [PCT_W-1:0]  val;
    } hsv_entry_t;

    hsv_entry_t hsv_due_q[$];
    int         fail_n;

    function automatic hsv_entry_t hsv_of_rgb(input logic [COMP_W-1:0] r,
                                              input logic [COMP_W-1:0] g,
                                              input logic [COMP_W-1:0] b);
        hsv_entry_t  px;
        int unsigned hi;
        int unsigned lo;
        int unsigned span;
        int unsigned num;
        sector_t     sect;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        span = hi - lo;
        // first component equal to the max wins the sector
        if (hi == r)
            sect = SECT_RED;
        else if (hi == g)
            sect = SECT_GREEN;
        else
            sect = SECT_BLUE;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        px.hue   = '0;
        if (span != 0) begin
            // numerator stays non-negative: the signed part never exceeds 60 * span
            case (sect)
                SECT_RED:   num = RED_BASE * span + SEXTANT_DEG * g - SEXTANT_DEG * b;
                SECT_GREEN: num = GREEN_BASE * span + SEXTANT_DEG * b - SEXTANT_DEG * r;
                default:    num = BLUE_BASE * span + SEXTANT_DEG * r - SEXTANT_DEG * g;
            endcase
            px.hue = HUE_W'((num / span) % WRAP_DEG);
        end
        px.sat = (hi != 0) ? PCT_W'((PCT_SCALE * span) / hi) : '0;
        px.val = PCT_W'((PCT_SCALE * hi) / FULL_SCALE);
        return px;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        hsv_entry_t want;
        if (!rst_n) begin
            hsv_due_q.delete();
            pending    <= 0;
            mismatches <= fail_n;
        end else begin
            if (rgb.valid && rgb.ready) begin
                hsv_due_q.push_back(hsv_of_rgb(rgb.red_in, rgb.green_in, rgb.blue_in));
                if (rgb.red_in == rgb.green_in && rgb.green_in == rgb.blue_in) begin
                    greys <= greys + 1;
                    if (rgb.red_in == '0)
                        blacks <= blacks + 1;
                end
            end
            if (hsv.valid && hsv.ready) begin
                if (hsv_due_q.size() == 0) begin
                    fail_n++;
                    if (fail_n <= REPORT_MAX)
                        $display("%0t: unexpected hsv item hue %0d sat %0d val %0d",
                                 $time, hsv.hue_deg, hsv.sat_pct, hsv.val_pct);
                end else begin
                    want = hsv_due_q.pop_front();
                    checked <= checked + 1;
                    if (hsv.hue_deg !== want.hue || hsv.sat_pct !== want.sat ||
                        hsv.val_pct !== want.val) begin
                        fail_n++;
                        if (fail_n <= REPORT_MAX)
                            $display({"%0t: rgb (%0d,%0d,%0d) expected hsv (%0d,%0d,%0d)",
                                      " got (%0d,%0d,%0d)"},
                                     $time, want.red, want.green, want.blue,
                                     want.hue, want.sat, want.val,
                                     hsv.hue_deg, hsv.sat_pct, hsv.val_pct);
                    end
                end
            end
            pending    <= hsv_due_q.size();
            mismatches <= fail_n;
        end
    end

endmodule

// ===== test/rgb_to_hsv_converter_test.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the rgb to hsv converter. A checker beside the
// block predicts every hsv item and compares; this module only feeds pixels,
// throttles the output side and decides the outcome.
module rgb_to_hsv_converter_test;
    import rth_pkg::*;

    localparam int ITEMS_PER_PHASE = 400;
    localparam int PHASES          = 4;
    localparam int MAX_GAP         = 5;
    localparam int HOLD_CYCLES     = 300;   // long output stall, well past pipeline depth
    localparam int DRAIN_CYCLES    = 16;    // pipeline latency plus margin
    localparam int WATCHDOG_LIMIT  = 2000;  // cycles with no handshake on either side

    localparam logic [COMP_W-1:0] TOP = '1;

    logic clk;
    logic rst_n;

    rth_rgb_if rgb();
    rth_hsv_if hsv();

    int mismatches;
    int pending;
    int checked;
    int greys;
    int blacks;
    int idle_cycles;

    // steady flags switch off random idling on one side for a whole phase
    bit tx_steady;
    bit rx_steady;
    bit rx_hold_request;

    rgb_to_hsv_converter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rgb   (rgb),
        .hsv   (hsv)
    );

    hsv_result_checker hsv_watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .rgb        (rgb),
        .hsv        (hsv),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked),
        .greys      (greys),
        .blacks     (blacks)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: any handshake resets the count, a long silence ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (rgb.valid && rgb.ready) || (hsv.valid && hsv.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one pixel after a random gap and hold it until the block takes it.
    // Returns at the edge where the item was accepted, so the next call can
    // keep valid high for back-to-back traffic.
    task automatic send_pixel(input logic [COMP_W-1:0] r,
                              input logic [COMP_W-1:0] g,
                              input logic [COMP_W-1:0] b);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            rgb.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rgb.valid    <= 1'b1;
        rgb.red_in   <= r;
        rgb.green_in <= g;
        rgb.blue_in  <= b;
        do
            @(posedge clk);
        while (!rgb.ready);
    endtask

    // Component near the ends of the range, or anywhere now and then.
    function automatic logic [COMP_W-1:0] corner_value();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return COMP_W'(1);
            2:       return TOP - 1'b1;
            3:       return TOP;
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // Random pixel, biased toward ties, greys, range ends and near-ties so the
    // sector choice and the hue wrap get exercised far more than uniform
    // values alone would.
    task automatic send_random_pixel();
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        r = COMP_W'($urandom);
        g = COMP_W'($urandom);
        b = COMP_W'($urandom);
        case ($urandom_range(0, 9))
            0: g = r;                                       // red and green tie
            1: b = g;                                       // green and blue tie
            2: b = r;                                       // red and blue tie
            3:
            begin
                g = r;                                      // grey
                b = r;
            end
            4, 5:
            begin
                r = corner_value();
                g = corner_value();
                b = corner_value();
            end
            6: g = r - COMP_W'($urandom_range(0, 3));       // hue close to a sector edge
            default: ;
        endcase
        send_pixel(r, g, b);
    endtask

    // Drop valid and wait until every predicted item has come back.
    task automatic drain_results();
        rgb.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Output side: per item, stall a random number of cycles (none in steady
    // phases), or hold off for a long stretch once when asked, so the
    // pipeline fills and back-pressure reaches the input.
    initial
    begin : result_sink
        int gap;
        hsv.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                hsv.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0)
                begin
                    hsv.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            hsv.ready <= 1'b1;
            do
                @(posedge clk);
            while (!hsv.valid);
        end
    end

    initial
    begin : pixel_source
        int phase;
        rst_n           = 1'b0;
        rgb.valid       = 1'b0;
        rgb.red_in      = '0;
        rgb.green_in    = '0;
        rgb.blue_in     = '0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        rx_hold_request = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners: black, white and greys, the pure primaries, every
        // tie for the maximum, the red sector wrap on both sides of zero, and
        // a few pixels at the edges of each sector.
        send_pixel('0, '0, '0);
        send_pixel(TOP, TOP, TOP);
        send_pixel(8'd128, 8'd128, 8'd128);
        send_pixel(8'd1, 8'd1, 8'd1);
        send_pixel(TOP, '0, '0);
        send_pixel('0, TOP, '0);
        send_pixel('0, '0, TOP);
        send_pixel(TOP, TOP, '0);
        send_pixel('0, TOP, TOP);
        send_pixel(TOP, '0, TOP);
        send_pixel(TOP, '0, 8'd1);
        send_pixel(8'd1, '0, '0);
        send_pixel(TOP, 8'd254, '0);
        send_pixel('0, 8'd254, TOP);
        send_pixel(8'd254, '0, TOP);
        send_pixel('0, 8'd1, '0);
        send_pixel('0, '0, 8'd1);
        send_pixel(8'd170, 8'd85, '0);
        send_pixel(8'd100, 8'd50, 8'd200);
        send_pixel(8'd254, 8'd1, 8'd128);
        send_pixel(8'd85, 8'd170, TOP);
        send_pixel(8'd2, 8'd1, '0);
        drain_results();

        // Random phases: gapped on both sides, fully back-to-back, steady
        // output with one long hold-off, then steady input against a
        // stalling output. Pause the input between phases until drained.
        for (phase = 0; phase < PHASES; phase++)
        begin
            tx_steady = (phase == 1) || (phase == 3);
            rx_steady = (phase == 1) || (phase == 2);
            if (phase == 2)
                rx_hold_request = 1'b1;
            repeat (ITEMS_PER_PHASE) send_random_pixel();
            drain_results();
        end

        // Let anything stray surface before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d pixels through the converter, %0d of them grey and %0d black.",
                 checked, greys, blacks);
        $display("Covered corner colors, sector ties and wraps, burst and gapped traffic, "
                 , "and a long output stall.");
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
